@@ design/ycbd_pkg.sv @@
package ycbd_pkg;

	// Frame geometry.
	localparam int SRC_WIDTH  = 320;
	localparam int SRC_HEIGHT = 240;
	localparam int OUT_SIZE   = 128;
	localparam int PAIRS      = SRC_WIDTH / 2;

	// Counter widths, sized so that each counter can hold its own limit.
	localparam int PCOL_W = $clog2(PAIRS + 1);
	localparam int SROW_W = $clog2(SRC_HEIGHT + 1);
	localparam int OCNT_W = $clog2(OUT_SIZE + 1);
	localparam int CTGT_W = $clog2(SRC_WIDTH + 1);
	localparam int RTGT_W = $clog2(SRC_HEIGHT + 1);
	localparam int REM_W  = $clog2(OUT_SIZE + 1);

	// Fixed field widths.
	localparam int PIX_W = 8;
	localparam int POS_W = 7;

	// Per-step increments of the source targets, as quotient and remainder.
	localparam logic [CTGT_W-1:0] CSTEP_Q = CTGT_W'(SRC_WIDTH / OUT_SIZE);
	localparam logic [REM_W:0]    CSTEP_R = (REM_W + 1)'(SRC_WIDTH % OUT_SIZE);
	localparam logic [RTGT_W-1:0] RSTEP_Q = RTGT_W'(SRC_HEIGHT / OUT_SIZE);
	localparam logic [REM_W:0]    RSTEP_R = (REM_W + 1)'(SRC_HEIGHT % OUT_SIZE);
	localparam logic [REM_W:0]    OUT_SIZE_R = (REM_W + 1)'(OUT_SIZE);

	// Conversion coefficients, scaled by 1024.
	localparam logic signed [11:0] K_RV = 12'sd1436;
	localparam logic signed [11:0] K_GU = 12'sd352;
	localparam logic signed [11:0] K_GV = 12'sd731;
	localparam logic signed [11:0] K_BU = 12'sd1814;
	localparam logic [PIX_W-1:0]   CHROMA_MID = 8'd128;
	localparam int                 FRAC_BITS  = 10;

	// Depth of the queue between front and back, and of the result queue.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// A selected pair, ready for color conversion.
	typedef struct packed {
		logic [PIX_W-1:0] cb;
		logic [PIX_W-1:0] cr;
		logic [PIX_W-1:0] luma;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic             last;
	} ycbd_item_t;

	// One finished output pixel.
	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic             last;
	} ycbd_res_t;

endpackage

@@ design/ycbd_front.sv @@
module ycbd_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [ycbd_pkg::PIX_W-1:0] cb,
	input  logic [ycbd_pkg::PIX_W-1:0] y_even,
	input  logic [ycbd_pkg::PIX_W-1:0] cr,
	input  logic [ycbd_pkg::PIX_W-1:0] y_odd,
	input  logic                      frame_start,
	output logic                      item_valid,
	output ycbd_pkg::ycbd_item_t      item
);

	logic [ycbd_pkg::PCOL_W-1:0] pcol_q, pcol_e, pcol_n;
	logic [ycbd_pkg::SROW_W-1:0] srow_q, srow_e, srow_n;
	logic [ycbd_pkg::OCNT_W-1:0] ocol_q, ocol_e, ocol_n;
	logic [ycbd_pkg::OCNT_W-1:0] orow_q, orow_e, orow_n;
	logic [ycbd_pkg::CTGT_W-1:0] ctgt_q, ctgt_e, ctgt_n;
	logic [ycbd_pkg::REM_W-1:0]  crem_q, crem_e, crem_n;
	logic [ycbd_pkg::RTGT_W-1:0] rtgt_q, rtgt_e, rtgt_n;
	logic [ycbd_pkg::REM_W-1:0]  rrem_q, rrem_e, rrem_n;
	logic                        done_q, done_e, done_n;
	logic [ycbd_pkg::REM_W:0]    csum, rsum;
	logic                        match, last;

	// A frame start beat sees the position state as just after reset.
	always_comb begin
		pcol_e = frame_start ? '0 : pcol_q;
		srow_e = frame_start ? '0 : srow_q;
		ocol_e = frame_start ? '0 : ocol_q;
		orow_e = frame_start ? '0 : orow_q;
		ctgt_e = frame_start ? '0 : ctgt_q;
		crem_e = frame_start ? '0 : crem_q;
		rtgt_e = frame_start ? '0 : rtgt_q;
		rrem_e = frame_start ? '0 : rrem_q;
		done_e = frame_start ? 1'b0 : done_q;
	end

	// The pair is selected once it reaches the target row and column.
	assign match = !done_e && (srow_e >= ycbd_pkg::SROW_W'(rtgt_e))
		&& ((ctgt_e >> 1) <= ycbd_pkg::CTGT_W'(pcol_e));

	assign csum = {1'b0, crem_e} + ycbd_pkg::CSTEP_R;
	assign rsum = {1'b0, rrem_e} + ycbd_pkg::RSTEP_R;

	// Next position state: output stepping first, then the source raster.
	always_comb begin
		pcol_n = pcol_e;
		srow_n = srow_e;
		ocol_n = ocol_e;
		orow_n = orow_e;
		ctgt_n = ctgt_e;
		crem_n = crem_e;
		rtgt_n = rtgt_e;
		rrem_n = rrem_e;
		done_n = done_e;
		last   = 1'b0;
		if (match) begin
			if (ocol_e == ycbd_pkg::OCNT_W'(ycbd_pkg::OUT_SIZE - 1)) begin
				ocol_n = '0;
				ctgt_n = '0;
				crem_n = '0;
				if (orow_e == ycbd_pkg::OCNT_W'(ycbd_pkg::OUT_SIZE - 1)) begin
					last   = 1'b1;
					done_n = 1'b1;
					orow_n = '0;
					rtgt_n = '0;
					rrem_n = '0;
				end else begin
					orow_n = orow_e + 1'b1;
					if (rsum >= ycbd_pkg::OUT_SIZE_R) begin
						rrem_n = ycbd_pkg::REM_W'(rsum - ycbd_pkg::OUT_SIZE_R);
						rtgt_n = rtgt_e + ycbd_pkg::RSTEP_Q + 1'b1;
					end else begin
						rrem_n = ycbd_pkg::REM_W'(rsum);
						rtgt_n = rtgt_e + ycbd_pkg::RSTEP_Q;
					end
				end
			end else begin
				ocol_n = ocol_e + 1'b1;
				if (csum >= ycbd_pkg::OUT_SIZE_R) begin
					crem_n = ycbd_pkg::REM_W'(csum - ycbd_pkg::OUT_SIZE_R);
					ctgt_n = ctgt_e + ycbd_pkg::CSTEP_Q + 1'b1;
				end else begin
					crem_n = ycbd_pkg::REM_W'(csum);
					ctgt_n = ctgt_e + ycbd_pkg::CSTEP_Q;
				end
			end
		end
		if (pcol_e == ycbd_pkg::PCOL_W'(ycbd_pkg::PAIRS - 1)) begin
			pcol_n = '0;
			if (srow_e == ycbd_pkg::SROW_W'(ycbd_pkg::SRC_HEIGHT - 1)) begin
				// Source frame wraps: everything returns to its reset value.
				srow_n = '0;
				ocol_n = '0;
				orow_n = '0;
				ctgt_n = '0;
				crem_n = '0;
				rtgt_n = '0;
				rrem_n = '0;
				done_n = 1'b0;
			end else begin
				srow_n = srow_e + 1'b1;
				if (!done_n) begin
					ocol_n = '0;
					ctgt_n = '0;
					crem_n = '0;
				end
			end
		end else begin
			pcol_n = pcol_e + 1'b1;
		end
	end

	// Position state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcol_q <= '0;
			srow_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			ctgt_q <= '0;
			crem_q <= '0;
			rtgt_q <= '0;
			rrem_q <= '0;
			done_q <= 1'b0;
		end else if (accept) begin
			pcol_q <= pcol_n;
			srow_q <= srow_n;
			ocol_q <= ocol_n;
			orow_q <= orow_n;
			ctgt_q <= ctgt_n;
			crem_q <= crem_n;
			rtgt_q <= rtgt_n;
			rrem_q <= rrem_n;
			done_q <= done_n;
		end
	end

	// Selected pair, with the luma picked by the target column parity.
	assign item_valid = accept && match;
	assign item.cb    = cb;
	assign item.cr    = cr;
	assign item.luma  = ctgt_e[0] ? y_odd : y_even;
	assign item.x     = ycbd_pkg::POS_W'(32'(ocol_e));
	assign item.y     = ycbd_pkg::POS_W'(32'(orow_e));
	assign item.last  = last;

endmodule

@@ design/ycbd_queue.sv @@
module ycbd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ycbd_pkg::ycbd_item_t din,
	output logic                 full,
	input  logic                 pop,
	output ycbd_pkg::ycbd_item_t dout,
	output logic                 empty
);

	ycbd_pkg::ycbd_item_t            mem_q [ycbd_pkg::QDEPTH];
	logic [ycbd_pkg::QPTR_W-1:0]     wptr_q, rptr_q;
	logic [ycbd_pkg::QCNT_W-1:0]     count_q;
	logic                            do_push, do_pop;

	assign full    = (count_q == ycbd_pkg::QCNT_W'(ycbd_pkg::QDEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rptr_q];

	// Storage; entries need no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= din;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/ycbd_back.sv @@
module ycbd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_empty,
	input  ycbd_pkg::ycbd_item_t item,
	output logic                 item_pop,
	input  logic                 res_pop,
	output logic                 res_empty,
	output ycbd_pkg::ycbd_res_t  res
);

	logic                          issue;
	logic signed [8:0]             du, dv;
	logic signed [20:0]            p_rv, p_gu, p_gv, p_bu;
	logic                          v_s1;
	logic [ycbd_pkg::PIX_W-1:0]    luma_s1;
	logic signed [9:0]             off_r_s1, off_gu_s1, off_gv_s1, off_b_s1;
	logic [ycbd_pkg::POS_W-1:0]    x_s1, y_s1;
	logic                          last_s1;
	logic signed [10:0]            sum_r, sum_g, sum_b, luma_x;
	ycbd_pkg::ycbd_res_t           res_new;
	ycbd_pkg::ycbd_res_t           mem_q [ycbd_pkg::QDEPTH];
	logic [ycbd_pkg::QPTR_W-1:0]   wptr_q, rptr_q;
	logic [ycbd_pkg::QCNT_W-1:0]   count_q;
	logic                          do_pop;

	function automatic logic [ycbd_pkg::PIX_W-1:0] clamp8(input logic signed [10:0] v);
		logic [ycbd_pkg::PIX_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > 11'sd255) begin
			r = '1;
		end else begin
			r = v[ycbd_pkg::PIX_W-1:0];
		end
		return r;
	endfunction

	// Take a beat only when the result queue has room for it and the one in flight.
	assign issue    = !item_empty
		&& ((count_q + ycbd_pkg::QCNT_W'(v_s1)) < ycbd_pkg::QCNT_W'(ycbd_pkg::QDEPTH));
	assign item_pop = issue;

	// Stage 1: chroma products, floored by the arithmetic shift.
	assign du   = $signed({1'b0, item.cb}) - $signed({1'b0, ycbd_pkg::CHROMA_MID});
	assign dv   = $signed({1'b0, item.cr}) - $signed({1'b0, ycbd_pkg::CHROMA_MID});
	assign p_rv = 21'(ycbd_pkg::K_RV) * 21'(dv);
	assign p_gu = 21'(ycbd_pkg::K_GU) * 21'(du);
	assign p_gv = 21'(ycbd_pkg::K_GV) * 21'(dv);
	assign p_bu = 21'(ycbd_pkg::K_BU) * 21'(du);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			luma_s1   <= item.luma;
			off_r_s1  <= 10'(p_rv >>> ycbd_pkg::FRAC_BITS);
			off_gu_s1 <= 10'(p_gu >>> ycbd_pkg::FRAC_BITS);
			off_gv_s1 <= 10'(p_gv >>> ycbd_pkg::FRAC_BITS);
			off_b_s1  <= 10'(p_bu >>> ycbd_pkg::FRAC_BITS);
			x_s1      <= item.x;
			y_s1      <= item.y;
			last_s1   <= item.last;
		end
	end

	// Stage 2: add luma and clamp each channel to a byte.
	assign luma_x = $signed({3'b000, luma_s1});
	assign sum_r  = luma_x + {off_r_s1[9], off_r_s1};
	assign sum_g  = luma_x - {off_gu_s1[9], off_gu_s1} - {off_gv_s1[9], off_gv_s1};
	assign sum_b  = luma_x + {off_b_s1[9], off_b_s1};

	assign res_new.red   = clamp8(sum_r);
	assign res_new.green = clamp8(sum_g);
	assign res_new.blue  = clamp8(sum_b);
	assign res_new.x     = x_s1;
	assign res_new.y     = y_s1;
	assign res_new.last  = last_s1;

	// Result queue: holds finished pixels until the consumer pops them.
	assign res_empty = (count_q == '0);
	assign do_pop    = res_pop && !res_empty;
	assign res       = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (v_s1) begin
			mem_q[wptr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (v_s1) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (v_s1 && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !v_s1) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/ycbcr422_downscale_to_rgb.sv @@
// A selected pixel passes the middle queue, the stage 1 registers and the result
// queue to the result ports. Throughput: one pixel pair per cycle while full is
// low; the position counters in the front update once per accepted beat and the
// two-stage converter takes one per cycle while the result queue has room.
// Reset (arst_n low) clears position counters, frame state and both queues.
module ycbcr422_downscale_to_rgb (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [ycbd_pkg::PIX_W-1:0] cb,
	input  logic [ycbd_pkg::PIX_W-1:0] y_even,
	input  logic [ycbd_pkg::PIX_W-1:0] cr,
	input  logic [ycbd_pkg::PIX_W-1:0] y_odd,
	input  logic                       frame_start,
	output logic                       empty,
	input  logic                       pop,
	output logic [ycbd_pkg::PIX_W-1:0] red,
	output logic [ycbd_pkg::PIX_W-1:0] green,
	output logic [ycbd_pkg::PIX_W-1:0] blue,
	output logic [ycbd_pkg::POS_W-1:0] out_x,
	output logic [ycbd_pkg::POS_W-1:0] out_y,
	output logic                       frame_last
);

	logic                 accept;
	logic                 item_valid;
	ycbd_pkg::ycbd_item_t front_item, back_item;
	logic                 mid_empty, mid_pop;
	ycbd_pkg::ycbd_res_t  res;

	// A beat is taken whenever the middle queue has room.
	assign accept = push && !full;

	ycbd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.cb          (cb),
		.y_even      (y_even),
		.cr          (cr),
		.y_odd       (y_odd),
		.frame_start (frame_start),
		.item_valid  (item_valid),
		.item        (front_item)
	);

	ycbd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (item_valid),
		.din    (front_item),
		.full   (full),
		.pop    (mid_pop),
		.dout   (back_item),
		.empty  (mid_empty)
	);

	ycbd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_empty (mid_empty),
		.item       (back_item),
		.item_pop   (mid_pop),
		.res_pop    (pop),
		.res_empty  (empty),
		.res        (res)
	);

	assign red        = res.red;
	assign green      = res.green;
	assign blue       = res.blue;
	assign out_x      = res.x;
	assign out_y      = res.y;
	assign frame_last = res.last;

endmodule

@@ bench/tb_ycbcr422_downscale_to_rgb.sv @@
module tb_ycbcr422_downscale_to_rgb;
	import ycbd_pkg::*;

	// One 4:2:2 pixel pair as it is offered to the block.
	typedef struct packed {
		logic [PIX_W-1:0] cb;
		logic [PIX_W-1:0] y_even;
		logic [PIX_W-1:0] cr;
		logic [PIX_W-1:0] y_odd;
		logic             frame_start;
	} ycbcr_pair_t;

	localparam int STALL_LIMIT    = 3000;
	localparam int HOLD_CYCLES    = 300;
	localparam int RANDOM_PAIRS   = 1000;
	localparam int STEADY_PAIRS   = 400;
	localparam int TAIL_CYCLES    = 20;
	localparam int IDLE_PERCENT   = 6;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             push = 1'b0;
	logic             full;
	logic [PIX_W-1:0] cb = '0;
	logic [PIX_W-1:0] y_even = '0;
	logic [PIX_W-1:0] cr = '0;
	logic [PIX_W-1:0] y_odd = '0;
	logic             frame_start = 1'b0;
	logic             empty;
	logic             pop = 1'b0;
	logic [PIX_W-1:0] red;
	logic [PIX_W-1:0] green;
	logic [PIX_W-1:0] blue;
	logic [POS_W-1:0] out_x;
	logic [POS_W-1:0] out_y;
	logic             frame_last;

	ycbcr422_downscale_to_rgb dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.cb(cb),
		.y_even(y_even),
		.cr(cr),
		.y_odd(y_odd),
		.frame_start(frame_start),
		.empty(empty),
		.pop(pop),
		.red(red),
		.green(green),
		.blue(blue),
		.out_x(out_x),
		.out_y(out_y),
		.frame_last(frame_last)
	);

	always #2 clk = ~clk;

	// Pixels predicted but not yet seen on the result side.
	ycbd_res_t expected_pixels[$];
	int        fail_count = 0;

	// Idling controls of the stimulus and the receiver, and the watchdog's stall count.
	bit sender_idles = 1'b1;
	bit receiver_idles = 1'b1;
	int hold_request = 0;
	int hold_left = 0;
	int stall_cycles = 0;

	// Position tracker of the predictor.
	logic [PCOL_W-1:0] pos_pair;
	logic [SROW_W-1:0] pos_row;
	logic [OCNT_W-1:0] next_ox;
	logic [OCNT_W-1:0] next_oy;
	logic [CTGT_W-1:0] col_pick;
	logic [REM_W-1:0]  col_frac;
	logic [RTGT_W-1:0] row_pick;
	logic [REM_W-1:0]  row_frac;
	bit                frame_complete;

	function automatic void clear_position();
		pos_pair = '0;
		pos_row = '0;
		next_ox = '0;
		next_oy = '0;
		col_pick = '0;
		col_frac = '0;
		row_pick = '0;
		row_frac = '0;
		frame_complete = 1'b0;
	endfunction

	function automatic logic [PIX_W-1:0] clamp_channel(input int v);
		if (v < 0)
			return '0;
		if (v > 255)
			return 8'd255;
		return PIX_W'(v);
	endfunction

	// Advances the tracker by one accepted pair and queues the pixel it selects.
	function automatic void predict_pair(input ycbcr_pair_t p);
		int        du;
		int        dv;
		int        luma;
		ycbd_res_t px;
		if (p.frame_start)
			clear_position();
		if (!frame_complete && pos_row >= row_pick && (col_pick >> 1) <= pos_pair) begin
			du = int'(p.cb) - int'(CHROMA_MID);
			dv = int'(p.cr) - int'(CHROMA_MID);
			luma = col_pick[0] ? int'(p.y_odd) : int'(p.y_even);
			// Arithmetic shift on a signed product rounds toward minus infinity.
			px.red = clamp_channel(luma + ((K_RV * dv) >>> FRAC_BITS));
			px.green = clamp_channel(luma - ((K_GU * du) >>> FRAC_BITS)
				- ((K_GV * dv) >>> FRAC_BITS));
			px.blue = clamp_channel(luma + ((K_BU * du) >>> FRAC_BITS));
			px.x = next_ox[POS_W-1:0];
			px.y = next_oy[POS_W-1:0];
			px.last = 1'b0;
			if (next_ox + 1 >= OUT_SIZE) begin
				next_ox = '0;
				col_pick = '0;
				col_frac = '0;
				if (next_oy + 1 >= OUT_SIZE) begin
					px.last = 1'b1;
					frame_complete = 1'b1;
					next_oy = '0;
					row_pick = '0;
					row_frac = '0;
				end else begin
					next_oy++;
					row_pick += RSTEP_Q;
					row_frac += RSTEP_R;
					if (row_frac >= OUT_SIZE) begin
						row_frac -= OUT_SIZE;
						row_pick++;
					end
				end
			end else begin
				next_ox++;
				col_pick += CSTEP_Q;
				col_frac += CSTEP_R;
				if (col_frac >= OUT_SIZE) begin
					col_frac -= OUT_SIZE;
					col_pick++;
				end
			end
			expected_pixels.push_back(px);
		end
		// End of a source row, and wrap to a new frame after the last row.
		if (pos_pair + 1 >= PAIRS) begin
			pos_pair = '0;
			if (pos_row + 1 >= SRC_HEIGHT) begin
				clear_position();
			end else begin
				pos_row++;
				if (!frame_complete) begin
					next_ox = '0;
					col_pick = '0;
					col_frac = '0;
				end
			end
		end else begin
			pos_pair++;
		end
	endfunction

	function automatic ycbcr_pair_t random_pair(input bit start);
		ycbcr_pair_t p;
		p.cb = PIX_W'($urandom);
		p.y_even = PIX_W'($urandom);
		p.cr = PIX_W'($urandom);
		p.y_odd = PIX_W'($urandom);
		p.frame_start = start;
		return p;
	endfunction

	// Offers one pair; called at a falling edge and returns at a falling edge.
	task automatic send_pair(input ycbcr_pair_t p);
		while (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		cb <= p.cb;
		y_even <= p.y_even;
		cr <= p.cr;
		y_odd <= p.y_odd;
		frame_start <= p.frame_start;
		do
			@(posedge clk);
		while (full);
		predict_pair(p);
		@(negedge clk);
	endtask

	// Receiver: random idling plus an occasional long hold-off.
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else if (receiver_idles && $urandom_range(99) < IDLE_PERCENT) begin
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// Compare every popped beat with the oldest predicted pixel.
	always @(posedge clk) begin
		ycbd_res_t want;
		if (arst_n && pop && !empty) begin
			if (expected_pixels.size() == 0) begin
				$error("unexpected pixel at x %0d y %0d", out_x, out_y);
				fail_count++;
			end else begin
				want = expected_pixels.pop_front();
				if (red !== want.red) begin
					$error("red: expected %0d, actual %0d", want.red, red);
					fail_count++;
				end
				if (green !== want.green) begin
					$error("green: expected %0d, actual %0d", want.green, green);
					fail_count++;
				end
				if (blue !== want.blue) begin
					$error("blue: expected %0d, actual %0d", want.blue, blue);
					fail_count++;
				end
				if (out_x !== want.x) begin
					$error("out_x: expected %0d, actual %0d", want.x, out_x);
					fail_count++;
				end
				if (out_y !== want.y) begin
					$error("out_y: expected %0d, actual %0d", want.y, out_y);
					fail_count++;
				end
				if (frame_last !== want.last) begin
					$error("frame_last: expected %0d, actual %0d", want.last, frame_last);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: give up when no beat moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Color extremes on the first pixels of a frame, both luma parities.
	task automatic test_extremes();
		ycbcr_pair_t    p;
		logic [PIX_W-1:0] levels[3];
		levels[0] = 8'd0;
		levels[1] = 8'd128;
		levels[2] = 8'd255;
		for (int c = 0; c < 9; c++) begin
			p.cb = levels[c % 3];
			p.cr = levels[c / 3];
			p.y_even = c[0] ? 8'd255 : 8'd0;
			p.y_odd = ~p.y_even;
			p.frame_start = (c == 0);
			send_pair(p);
		end
		// Chroma one step either side of the midpoint; only the second pair is selected.
		send_pair('{8'd127, 8'd128, 8'd127, 8'd128, 1'b0});
		send_pair('{8'd129, 8'd1, 8'd129, 8'd254, 1'b0});
	endtask

	// A frame start in the middle of a row restarts the position counters.
	task automatic test_restart();
		for (int i = 0; i < 10; i++)
			send_pair(random_pair(i == 5));
	endtask

	// Mostly well-formed frame openings of random length, with stray frame starts.
	task automatic test_random_frames();
		int sent;
		int seg_len;
		sent = 0;
		while (sent < RANDOM_PAIRS) begin
			if ($urandom_range(3) == 0)
				seg_len = $urandom_range(1, 8);
			else
				seg_len = $urandom_range(20, 400);
			for (int i = 0; i < seg_len; i++) begin
				if (i == 0)
					send_pair(random_pair($urandom_range(99) < 85));
				else
					send_pair(random_pair($urandom_range(199) == 0));
			end
			sent += seg_len;
		end
	endtask

	// The receiver holds off while row 0 pairs keep arriving, so the block fills.
	task automatic test_backpressure();
		hold_request = HOLD_CYCLES;
		for (int i = 0; i < 80; i++)
			send_pair(random_pair(i == 0));
	endtask

	// A long stretch of back-to-back beats with neither side idling.
	task automatic test_steady_stream();
		sender_idles = 1'b0;
		receiver_idles = 1'b0;
		for (int i = 0; i < STEADY_PAIRS; i++)
			send_pair(random_pair(i == 0));
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
	endtask

	initial begin
		clear_position();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_extremes();
		test_restart();
		test_random_frames();
		test_backpressure();
		test_steady_stream();
		push <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
